@@ rtl/dsa_pkg.sv @@
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared types and constants for the debug slot allocator: request and
// status codes, field widths and control word layout.
// ----------------------------------------------------------------------------
package dsa_pkg;

    localparam int MAX_SLOTS   = 4;
    localparam int ADDR_W      = 64;
    localparam int CTRL_W      = 32;
    localparam int SLOT_W      = 2;
    localparam int NIBBLE_BASE = 16;
    localparam int SIZE_BASE   = 18;

    typedef enum logic [1:0] {
        REQ_SET   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BAD_MODE = 3'd2,
        ST_BAD_SIZE = 3'd3,
        ST_NO_HIT   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MODE_EXEC  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_RW    = 2'd2,
        MODE_BAD   = 2'd3
    } mode_t;

    // Control word encodings
    localparam logic [1:0] MC_EXEC  = 2'b00;
    localparam logic [1:0] MC_WRITE = 2'b01;
    localparam logic [1:0] MC_RW    = 2'b11;
    localparam logic [1:0] SC_1B    = 2'b00;
    localparam logic [1:0] SC_2B    = 2'b01;
    localparam logic [1:0] SC_4B    = 2'b11;
    localparam logic [1:0] SC_8B    = 2'b10;

endpackage

@@ rtl/debug_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// debug_slot_allocator
// Allocates, clears and looks up hardware watch/break slots held in a
// DR7-style control word and a bank of slot address registers.
// ----------------------------------------------------------------------------
// A request is taken on any cycle with start high (busy never rises); the
// block takes one request per cycle with no gaps. The request is captured
// in the input register, resolved by the single compute stage and captured
// in the result register, so done pulses for one cycle with status, slot,
// control_word and slot_address valid alongside it.
// Results come out in request order and cannot be held off: sample them
// whenever done is high. A request sees the effect of every earlier one.
module debug_slot_allocator #(
    parameter int NUM_SLOTS = dsa_pkg::MAX_SLOTS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  req_type,
    input  logic [dsa_pkg::ADDR_W-1:0]  address,
    input  logic [1:0]                  mode,
    input  logic [3:0]                  size_bytes,
    input  logic [dsa_pkg::SLOT_W-1:0]  slot_select,
    input  logic [3:0]                  hit_status,
    output logic                        done,
    output logic [2:0]                  status,
    output logic [dsa_pkg::SLOT_W-1:0]  slot,
    output logic [dsa_pkg::CTRL_W-1:0]  control_word,
    output logic [dsa_pkg::ADDR_W-1:0]  slot_address
);

    // Input register
    logic                        req_valid_reg;
    dsa_pkg::req_t               req_type_reg;
    logic [dsa_pkg::ADDR_W-1:0]  address_reg;
    dsa_pkg::mode_t              mode_reg;
    logic [3:0]                  size_reg;
    logic [dsa_pkg::SLOT_W-1:0]  slot_sel_reg;
    logic [3:0]                  hit_reg;

    // Architectural state
    logic [dsa_pkg::CTRL_W-1:0]  ctrl_reg;
    logic [dsa_pkg::CTRL_W-1:0]  ctrl_next;
    logic [dsa_pkg::ADDR_W-1:0]  slot_addr_reg [dsa_pkg::MAX_SLOTS];
    logic                        addr_we;
    logic [dsa_pkg::SLOT_W-1:0]  addr_wsel;
    logic [dsa_pkg::ADDR_W-1:0]  addr_wdata;

    // Result register
    logic                        done_reg;
    dsa_pkg::status_t            status_reg;
    dsa_pkg::status_t            status_next;
    logic [dsa_pkg::SLOT_W-1:0]  slot_reg;
    logic [dsa_pkg::SLOT_W-1:0]  slot_next;
    logic [dsa_pkg::ADDR_W-1:0]  slot_address_reg;
    logic [dsa_pkg::ADDR_W-1:0]  slot_address_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_type_reg <= dsa_pkg::req_t'(req_type);
            address_reg  <= address;
            mode_reg     <= dsa_pkg::mode_t'(mode);
            size_reg     <= size_bytes;
            slot_sel_reg <= slot_select;
            hit_reg      <= hit_status;
        end
    end

    // Resolve one transaction
    always_comb
    begin
        logic                       free_found;
        logic [dsa_pkg::SLOT_W-1:0] free_slot;
        logic                       hit_found;
        logic [dsa_pkg::SLOT_W-1:0] hit_slot;
        logic                       mode_ok;
        logic [1:0]                 mc;
        logic                       size_ok;
        logic [1:0]                 sc;
        logic [4:0]                 nib_lo;

        free_found = 1'b0;
        free_slot  = '0;
        hit_found  = 1'b0;
        hit_slot   = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (!free_found && ctrl_reg[2*i +: 2] == 2'b00)
            begin
                free_found = 1'b1;
                free_slot  = dsa_pkg::SLOT_W'(i);
            end
            if (!hit_found && hit_reg[i])
            begin
                hit_found = 1'b1;
                hit_slot  = dsa_pkg::SLOT_W'(i);
            end
        end

        mode_ok = 1'b1;
        case (mode_reg)
            dsa_pkg::MODE_EXEC:  mc = dsa_pkg::MC_EXEC;
            dsa_pkg::MODE_WRITE: mc = dsa_pkg::MC_WRITE;
            dsa_pkg::MODE_RW:    mc = dsa_pkg::MC_RW;
            default:
            begin
                mc      = 2'b00;
                mode_ok = 1'b0;
            end
        endcase

        size_ok = 1'b1;
        case (size_reg)
            4'd1:    sc = dsa_pkg::SC_1B;
            4'd2:    sc = dsa_pkg::SC_2B;
            4'd4:    sc = dsa_pkg::SC_4B;
            4'd8:    sc = dsa_pkg::SC_8B;
            default:
            begin
                sc      = 2'b00;
                size_ok = 1'b0;
            end
        endcase

        ctrl_next         = ctrl_reg;
        addr_we           = 1'b0;
        addr_wsel         = '0;
        addr_wdata        = '0;
        status_next       = dsa_pkg::ST_OK;
        slot_next         = '0;
        slot_address_next = '0;
        nib_lo            = '0;

        if (req_valid_reg)
        begin
            case (req_type_reg)
                dsa_pkg::REQ_SET:
                begin
                    if (!free_found)
                    begin
                        status_next = dsa_pkg::ST_FULL;
                    end
                    else if (!mode_ok)
                    begin
                        status_next = dsa_pkg::ST_BAD_MODE;
                    end
                    else if (!size_ok)
                    begin
                        status_next = dsa_pkg::ST_BAD_SIZE;
                    end
                    else
                    begin
                        nib_lo = 5'(dsa_pkg::NIBBLE_BASE) + {1'b0, free_slot, 2'b00};
                        ctrl_next[{free_slot, 1'b0} +: 2] = 2'b01;
                        ctrl_next[nib_lo +: 4]            = {sc, mc};
                        slot_next  = free_slot;
                        addr_we    = 1'b1;
                        addr_wsel  = free_slot;
                        addr_wdata = address_reg;
                    end
                end
                dsa_pkg::REQ_CLEAR:
                begin
                    slot_next = slot_sel_reg;
                    if (int'(slot_sel_reg) < NUM_SLOTS)
                    begin
                        nib_lo = 5'(dsa_pkg::NIBBLE_BASE) + {1'b0, slot_sel_reg, 2'b00};
                        ctrl_next[{slot_sel_reg, 1'b0} +: 2] = 2'b00;
                        ctrl_next[nib_lo +: 4]               = 4'b0000;
                        addr_we   = 1'b1;
                        addr_wsel = slot_sel_reg;
                    end
                end
                dsa_pkg::REQ_QUERY:
                begin
                    if (hit_found)
                    begin
                        slot_next         = hit_slot;
                        slot_address_next = slot_addr_reg[hit_slot];
                    end
                    else
                    begin
                        status_next = dsa_pkg::ST_NO_HIT;
                    end
                end
                default:
                begin
                    status_next = dsa_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
            for (int i = 0; i < dsa_pkg::MAX_SLOTS; i++)
            begin
                slot_addr_reg[i] <= '0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
            if (addr_we)
            begin
                slot_addr_reg[addr_wsel] <= addr_wdata;
            end
            done_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            status_reg       <= status_next;
            slot_reg         <= slot_next;
            slot_address_reg <= slot_address_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign slot         = slot_reg;
    assign control_word = ctrl_reg;
    assign slot_address = slot_address_reg;

    // Checks
    a_done_follows_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(req_valid_reg))
        else $error("done without a registered transaction");

    a_error_keeps_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        done && status_reg != dsa_pkg::ST_OK |-> control_word == $past(ctrl_reg))
        else $error("failed transaction changed the control word");

    a_error_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        done && status_reg != dsa_pkg::ST_OK |-> slot_address == '0)
        else $error("address returned on a failed transaction");

    a_set_enables: assert property (@(posedge clk) disable iff (!rst_n)
        done && status_reg == dsa_pkg::ST_OK && $past(req_type_reg) == dsa_pkg::REQ_SET
        |-> ((control_word >> {slot, 1'b0}) & 32'd3) == 32'd1)
        else $error("allocated slot not locally enabled");

endmodule

@@ verif/debug_slot_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debug_slot_allocator_tb
// Self-checking bench for the debug slot allocator. A queue-fed driver issues
// set, clear and query transactions in random bursts. A shadow copy of the
// control word and slot addresses predicts every result, and a monitor checks
// each done pulse against the oldest prediction.
// ----------------------------------------------------------------------------
module debug_slot_allocator_tb;

    localparam int SLOTS       = dsa_pkg::MAX_SLOTS;
    localparam int QUIET_LIMIT = 500;
    localparam int RANDOM_REQS = 1025;
    localparam int SETTLE      = 6;

    typedef struct {
        logic [1:0]                 req;
        logic [dsa_pkg::ADDR_W-1:0] addr;
        logic [1:0]                 mode;
        logic [3:0]                 size;
        logic [dsa_pkg::SLOT_W-1:0] sel;
        logic [3:0]                 hits;
    } slot_req_t;

    typedef struct {
        logic [2:0]                 status;
        logic [dsa_pkg::SLOT_W-1:0] slot;
        logic [dsa_pkg::CTRL_W-1:0] ctrl;
        logic [dsa_pkg::ADDR_W-1:0] addr;
    } slot_outcome_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [1:0]                  req_type = dsa_pkg::REQ_NONE;
    logic [dsa_pkg::ADDR_W-1:0]  address = '0;
    logic [1:0]                  mode = dsa_pkg::MODE_EXEC;
    logic [3:0]                  size_bytes = '0;
    logic [dsa_pkg::SLOT_W-1:0]  slot_select = '0;
    logic [3:0]                  hit_status = '0;
    logic                        done;
    logic [2:0]                  status;
    logic [dsa_pkg::SLOT_W-1:0]  slot;
    logic [dsa_pkg::CTRL_W-1:0]  control_word;
    logic [dsa_pkg::ADDR_W-1:0]  slot_address;

    slot_req_t                   pending_q[$];
    slot_outcome_t               outcome_q[$];
    slot_req_t                   cur_req;

    // shadow state of the block
    logic [dsa_pkg::CTRL_W-1:0]  dr7_shadow = '0;
    logic [dsa_pkg::ADDR_W-1:0]  addr_shadow [SLOTS];

    int                          fail_count = 0;
    int                          quiet_cycles = 0;
    int                          burst_left = 1;
    int                          gap_left = 0;

    debug_slot_allocator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .address      (address),
        .mode         (mode),
        .size_bytes   (size_bytes),
        .slot_select  (slot_select),
        .hit_status   (hit_status),
        .done         (done),
        .status       (status),
        .slot         (slot),
        .control_word (control_word),
        .slot_address (slot_address)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply one accepted transaction to the shadow state and queue its result.
    function automatic void resolve_request(input slot_req_t rq);
        slot_outcome_t o;
        logic [1:0]    mc;
        logic [1:0]    sc;
        logic          found;
        logic          mode_ok;
        logic          size_ok;
        int            s;
        o = '{default: '0};
        o.status = dsa_pkg::ST_OK;
        mc = dsa_pkg::MC_EXEC;
        sc = dsa_pkg::SC_1B;
        found = 1'b0;
        mode_ok = 1'b1;
        size_ok = 1'b1;
        case (rq.req)
            dsa_pkg::REQ_SET:
            begin
                // scan downwards so the lowest free slot wins
                for (s = SLOTS - 1; s >= 0; s--)
                    if (dr7_shadow[2*s +: 2] == 2'b00)
                    begin
                        found = 1'b1;
                        o.slot = dsa_pkg::SLOT_W'(s);
                    end
                case (rq.mode)
                    dsa_pkg::MODE_EXEC:  mc = dsa_pkg::MC_EXEC;
                    dsa_pkg::MODE_WRITE: mc = dsa_pkg::MC_WRITE;
                    dsa_pkg::MODE_RW:    mc = dsa_pkg::MC_RW;
                    default:             mode_ok = 1'b0;
                endcase
                case (rq.size)
                    4'd1:    sc = dsa_pkg::SC_1B;
                    4'd2:    sc = dsa_pkg::SC_2B;
                    4'd4:    sc = dsa_pkg::SC_4B;
                    4'd8:    sc = dsa_pkg::SC_8B;
                    default: size_ok = 1'b0;
                endcase
                if (!found)
                    o.status = dsa_pkg::ST_FULL;
                else if (!mode_ok)
                    o.status = dsa_pkg::ST_BAD_MODE;
                else if (!size_ok)
                    o.status = dsa_pkg::ST_BAD_SIZE;
                if (o.status != dsa_pkg::ST_OK)
                    o.slot = '0;
                else
                begin
                    s = int'(o.slot);
                    dr7_shadow[2*s +: 2] = 2'b01;
                    dr7_shadow[dsa_pkg::NIBBLE_BASE + 4*s +: 2] = mc;
                    dr7_shadow[dsa_pkg::SIZE_BASE + 4*s +: 2] = sc;
                    addr_shadow[s] = rq.addr;
                end
            end
            dsa_pkg::REQ_CLEAR:
            begin
                o.slot = rq.sel;
                s = int'(rq.sel);
                if (s < SLOTS)
                begin
                    addr_shadow[s] = '0;
                    dr7_shadow[2*s +: 2] = 2'b00;
                    dr7_shadow[dsa_pkg::NIBBLE_BASE + 4*s +: 4] = 4'b0000;
                end
            end
            dsa_pkg::REQ_QUERY:
            begin
                for (s = SLOTS - 1; s >= 0; s--)
                    if (rq.hits[s])
                    begin
                        found = 1'b1;
                        o.slot = dsa_pkg::SLOT_W'(s);
                    end
                if (found)
                    o.addr = addr_shadow[o.slot];
                else
                    o.status = dsa_pkg::ST_NO_HIT;
            end
            default:
            begin
            end
        endcase
        o.ctrl = dr7_shadow;
        outcome_q = {outcome_q, o};
    endfunction

    function automatic void queue_request(
        input logic [1:0]                 req,
        input logic [dsa_pkg::ADDR_W-1:0] addr,
        input logic [1:0]                 md,
        input logic [3:0]                 sz,
        input logic [dsa_pkg::SLOT_W-1:0] sel,
        input logic [3:0]                 hits
    );
        slot_req_t rq;
        rq.req  = req;
        rq.addr = addr;
        rq.mode = md;
        rq.size = sz;
        rq.sel  = sel;
        rq.hits = hits;
        pending_q = {pending_q, rq};
    endfunction

    // Sets, mostly well-formed, with clears and queries keeping the table churning.
    function automatic slot_req_t random_request();
        slot_req_t rq;
        int        pick;
        rq.addr = {$urandom, $urandom};
        rq.mode = 2'($urandom_range(0, 3));
        rq.size = 4'($urandom_range(0, 15));
        rq.sel  = dsa_pkg::SLOT_W'($urandom_range(0, 3));
        rq.hits = 4'($urandom_range(0, 15));
        pick = int'($urandom_range(0, 99));
        if (pick < 40)
        begin
            rq.req = dsa_pkg::REQ_SET;
            if ($urandom_range(0, 9) != 0)
                rq.mode = 2'($urandom_range(dsa_pkg::MODE_EXEC, dsa_pkg::MODE_RW));
            if ($urandom_range(0, 6) != 0)
                rq.size = 4'd1 << $urandom_range(0, 3);
        end
        else if (pick < 65)
            rq.req = dsa_pkg::REQ_CLEAR;
        else if (pick < 94)
            rq.req = dsa_pkg::REQ_QUERY;
        else
            rq.req = dsa_pkg::REQ_NONE;
        return rq;
    endfunction

    // Driver: advance to the next queued transaction once the current one is taken.
    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
                resolve_request(cur_req);
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    cur_req = pending_q.pop_front();
                    start       <= 1'b1;
                    req_type    <= cur_req.req;
                    address     <= cur_req.addr;
                    mode        <= cur_req.mode;
                    size_bytes  <= cur_req.size;
                    slot_select <= cur_req.sel;
                    hit_status  <= cur_req.hits;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        if ($urandom_range(0, 7) == 0)
                        begin
                            burst_left = $urandom_range(20, 60);
                            gap_left   = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 12);
                            gap_left   = $urandom_range(0, 5);
                        end
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every done pulse must match the oldest outstanding prediction.
    always @(posedge clk)
    begin
        slot_outcome_t want;
        if (rst_n && done === 1'b1)
        begin
            if (outcome_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: status=%0d slot=%0d ctrl=%h addr=%h",
                             status, slot, control_word, slot_address);
            end
            else
            begin
                want = outcome_q.pop_front();
                if (status !== want.status || slot !== want.slot ||
                    control_word !== want.ctrl || slot_address !== want.addr)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: exp %0d/%0d/%h/%h got %0d/%0d/%h/%h",
                                 want.status, want.slot, want.ctrl, want.addr,
                                 status, slot, control_word, slot_address);
                end
            end
        end
    end

    // Watchdog: drop out if the block stops taking or returning transactions.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done === 1'b1)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        for (i = 0; i < SLOTS; i++)
            addr_shadow[i] = '0;

        // empty table, then fill all four slots with every mode and size
        queue_request(dsa_pkg::REQ_QUERY, '0, dsa_pkg::MODE_EXEC, 4'd0, 2'd0, 4'b0000);
        queue_request(dsa_pkg::REQ_QUERY, '0, dsa_pkg::MODE_EXEC, 4'd0, 2'd0, 4'b1111);
        queue_request(dsa_pkg::REQ_SET, '1, dsa_pkg::MODE_EXEC, 4'd1, 2'd0, 4'b0000);
        queue_request(dsa_pkg::REQ_SET, '0, dsa_pkg::MODE_WRITE, 4'd2, 2'd0, 4'b0000);
        queue_request(dsa_pkg::REQ_SET, 64'h0123_4567_89AB_CDEF, dsa_pkg::MODE_RW,
                      4'd4, 2'd3, 4'b1111);
        queue_request(dsa_pkg::REQ_SET, 64'h8000_0000_0000_0001, dsa_pkg::MODE_EXEC,
                      4'd8, 2'd1, 4'b0101);
        // full table outranks a bad mode and size
        queue_request(dsa_pkg::REQ_SET, '1, dsa_pkg::MODE_BAD, 4'd0, 2'd0, 4'b0000);
        queue_request(dsa_pkg::REQ_QUERY, '0, dsa_pkg::MODE_EXEC, 4'd0, 2'd0, 4'b1000);
        queue_request(dsa_pkg::REQ_QUERY, '0, dsa_pkg::MODE_EXEC, 4'd0, 2'd0, 4'b0100);
        queue_request(dsa_pkg::REQ_QUERY, '0, dsa_pkg::MODE_EXEC, 4'd0, 2'd0, 4'b0010);
        queue_request(dsa_pkg::REQ_QUERY, '0, dsa_pkg::MODE_EXEC, 4'd0, 2'd0, 4'b0001);
        queue_request(dsa_pkg::REQ_CLEAR, '0, dsa_pkg::MODE_EXEC, 4'd0, 2'd2, 4'b0000);
        // bad mode, then bad sizes, with a slot free
        queue_request(dsa_pkg::REQ_SET, '1, dsa_pkg::MODE_BAD, 4'd4, 2'd0, 4'b0000);
        queue_request(dsa_pkg::REQ_SET, '1, dsa_pkg::MODE_WRITE, 4'd0, 2'd0, 4'b0000);
        queue_request(dsa_pkg::REQ_SET, '1, dsa_pkg::MODE_RW, 4'd15, 2'd0, 4'b0000);
        queue_request(dsa_pkg::REQ_SET, '1, dsa_pkg::MODE_WRITE, 4'd3, 2'd0, 4'b0000);
        queue_request(dsa_pkg::REQ_SET, 64'hFFFF_0000_FFFF_0000, dsa_pkg::MODE_RW,
                      4'd8, 2'd0, 4'b0000);
        queue_request(dsa_pkg::REQ_QUERY, '0, dsa_pkg::MODE_EXEC, 4'd0, 2'd0, 4'b1100);
        queue_request(dsa_pkg::REQ_NONE, '1, dsa_pkg::MODE_BAD, 4'd15, 2'd3, 4'b1111);
        // clearing a slot twice is harmless
        queue_request(dsa_pkg::REQ_CLEAR, '0, dsa_pkg::MODE_EXEC, 4'd0, 2'd1, 4'b0000);
        queue_request(dsa_pkg::REQ_CLEAR, '0, dsa_pkg::MODE_EXEC, 4'd0, 2'd1, 4'b0000);
        queue_request(dsa_pkg::REQ_CLEAR, '0, dsa_pkg::MODE_EXEC, 4'd0, 2'd0, 4'b0000);
        queue_request(dsa_pkg::REQ_CLEAR, '0, dsa_pkg::MODE_EXEC, 4'd0, 2'd2, 4'b0000);
        queue_request(dsa_pkg::REQ_CLEAR, '0, dsa_pkg::MODE_EXEC, 4'd0, 2'd3, 4'b0000);
        queue_request(dsa_pkg::REQ_QUERY, '0, dsa_pkg::MODE_EXEC, 4'd0, 2'd0, 4'b1111);

        for (i = 0; i < RANDOM_REQS; i++)
            pending_q = {pending_q, random_request()};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || start)
            @(negedge clk);
        while (outcome_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
